// File: rtl/sap_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sap_pkg
// Types, constants and helper functions shared by the stereo phaser modules.
// ----------------------------------------------------------------------------
package sap_pkg;

    localparam int MAX_STAGES       = 24;
    localparam int LFO_INTERVAL     = 20;
    localparam int GAIN_TABLE_DEPTH = 256;
    localparam int GT_BITS          = $clog2(GAIN_TABLE_DEPTH);
    localparam int SKIP_W           = 5;
    localparam int CNT_W            = 7;

    // Feedback divider: 41-bit biased dividend, constant divisor of 100.
    localparam int DIV_W   = 41;
    localparam int FB_DIV  = 100;
    localparam logic signed [41:0] FB_BIAS = 42'sd858993459200;
    localparam logic signed [63:0] FB_BIAS_Q = 64'sd8589934592;

    // Reciprocal of the divisor: floor(2**42 / 100). The dividend is split into
    // a low part of FB_LO_W bits and the remaining high part.
    localparam int          FB_LO_W  = 21;
    localparam logic [35:0] FB_RECIP = 36'd43980465111;

    // Configuration register indexes.
    localparam logic [2:0] REG_LFO_STEP    = 3'd0;
    localparam logic [2:0] REG_START_PHASE = 3'd1;
    localparam logic [2:0] REG_FB_PERCENT  = 3'd2;
    localparam logic [2:0] REG_DEPTH       = 3'd3;
    localparam logic [2:0] REG_STAGE_COUNT = 3'd4;
    localparam logic [2:0] REG_DRY_WET     = 3'd5;

    localparam logic [63:0] ONE_Q30 = 64'd1 << 30;
    localparam logic [63:0] PI_Q30  = 64'd3373259426;

    localparam logic [63:0] EXP_DIV [1:16] = '{64'd1, 64'd2, 64'd3, 64'd4, 64'd5, 64'd6,
        64'd7, 64'd8, 64'd9, 64'd10, 64'd11, 64'd12, 64'd13, 64'd14, 64'd15, 64'd16};
    localparam logic [63:0] COS_DIV [1:7] = '{64'd2, 64'd12, 64'd30, 64'd56, 64'd90,
        64'd132, 64'd182};

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_CHAIN,
        S_MIX
    } t_state;

    typedef struct packed {
        logic signed [15:0] left_sample;
        logic signed [15:0] right_sample;
    } t_frame_in;

    typedef struct packed {
        logic signed [15:0] left_out;
        logic signed [15:0] right_out;
    } t_frame_out;

    // One channel's value travelling along the allpass chain.
    typedef struct packed {
        logic               valid;
        logic               ch;
        logic signed [31:0] data;
    } t_tok;

    typedef logic [16:0] t_gain_tab [GAIN_TABLE_DEPTH];

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -64'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // Product with the Q1.16 gain, rounded to nearest with ties upwards.
    function automatic logic signed [31:0] mul_gain(input logic signed [31:0] a,
                                                    input logic [16:0] g);
        logic signed [49:0] p;
        logic signed [49:0] r;
        p = a * $signed({1'b0, g});
        r = (p + 50'sd32768) >>> 16;
        return sat32(64'(r));
    endfunction

    // Floor of x / 255 for x below 2**24, by reciprocal and one correction.
    function automatic logic [16:0] div255(input logic [23:0] x);
        logic [39:0] p;
        logic [16:0] q;
        logic [24:0] b;
        p = {16'd0, x} * 40'd32897;
        q = p[39:23];
        b = {q, 8'd0} - {8'd0, q};
        if (b > {1'b0, x}) begin
            q = q - 17'd1;
        end
        return q;
    endfunction

    function automatic logic [63:0] exp4_q30(input logic [63:0] u);
        logic [63:0] sum;
        logic [63:0] term;
        logic [63:0] s;
        logic [63:0] q;
        sum  = ONE_Q30;
        term = ONE_Q30;
        for (int k = 1; k <= 16; k++) begin
            term = ((term * u) >> 30) / EXP_DIV[k];
            sum  = sum + term;
        end
        s = (sum * sum) >> 30;
        q = s >> 2;
        return (q * q) >> 26;
    endfunction

    localparam logic [63:0] SHAPE_DEN = exp4_q30(ONE_Q30) - ONE_Q30;

    function automatic logic [16:0] shape_q16(input int idx);
        logic [63:0]        x;
        logic [63:0]        t;
        logic [63:0]        t2;
        logic [63:0]        term;
        logic [63:0]        c;
        logic [63:0]        u;
        logic [63:0]        e;
        logic [63:0]        v;
        logic signed [63:0] sum;
        x    = (64'(idx) * 64'd65536) / 64'(GAIN_TABLE_DEPTH);
        term = ONE_Q30;
        sum  = $signed(ONE_Q30);
        if (x > 64'd32768) begin
            x = 64'd65536 - x;
        end
        t  = (x * PI_Q30) >> 16;
        t2 = (t * t) >> 30;
        for (int k = 1; k <= 7; k++) begin
            term = ((term * t2) >> 30) / COS_DIV[k];
            if ((k % 2) == 1) begin
                sum = sum - $signed(term);
            end else begin
                sum = sum + $signed(term);
            end
        end
        if (sum < 0) begin
            sum = 64'sd0;
        end
        if (sum > $signed(ONE_Q30)) begin
            sum = $signed(ONE_Q30);
        end
        c = sum;
        u = (c * c) >> 30;
        e = exp4_q30(u) - ONE_Q30;
        v = ((e << 16) + SHAPE_DEN / 64'd2) / SHAPE_DEN;
        if (v > 64'd65536) begin
            v = 64'd65536;
        end
        return v[16:0];
    endfunction

    function automatic t_gain_tab build_gain_tab();
        t_gain_tab tab;
        for (int i = 0; i < GAIN_TABLE_DEPTH; i++) begin
            tab[i] = shape_q16(i);
        end
        return tab;
    endfunction

    localparam t_gain_tab GAIN_TAB = build_gain_tab();

endpackage

// File: rtl/sap_div100.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sap_div100
// Two-lane divider by one hundred: reciprocal multiplication in two partial
// products, then one compare-and-increment correction of the estimate.
// ----------------------------------------------------------------------------
module sap_div100 (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [1:0][sap_pkg::DIV_W-1:0] i_num,
    output logic                          o_done,
    output logic [1:0][sap_pkg::DIV_W-1:0] o_quot
);

    logic [3:0]                                         r_stage;
    logic                                               r_done;
    logic [1:0][sap_pkg::DIV_W-1:0]                     r_x;
    logic [1:0][sap_pkg::FB_LO_W+35:0]                  r_plo;
    logic [1:0][sap_pkg::DIV_W-1:0]                     r_q;
    logic [1:0]                                         r_fix;
    logic [1:0][sap_pkg::DIV_W-1:0]                     r_quot;
    logic [1:0][sap_pkg::DIV_W-sap_pkg::FB_LO_W+35:0]   w_hi;
    logic [1:0][sap_pkg::DIV_W+35:0]                    w_sum;
    logic [1:0][sap_pkg::DIV_W-1:0]                     w_back;

    // The truncated reciprocal makes the estimate at most one below the
    // true quotient, so a single correction step is enough.
    always_comb begin
        for (int c = 0; c < 2; c++) begin
            w_hi[c]   = r_x[c][sap_pkg::DIV_W-1:sap_pkg::FB_LO_W] * sap_pkg::FB_RECIP;
            w_sum[c]  = (sap_pkg::DIV_W+36)'(r_plo[c])
                        + {w_hi[c], sap_pkg::FB_LO_W'(0)};
            w_back[c] = r_x[c] - r_q[c] * sap_pkg::DIV_W'(sap_pkg::FB_DIV);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage <= '0;
            r_done  <= 1'b0;
        end else begin
            r_stage <= {r_stage[2:0], i_start};
            r_done  <= r_stage[3];
        end
        if (i_start) begin
            r_x <= i_num;
        end
        for (int c = 0; c < 2; c++) begin
            if (r_stage[0]) begin
                r_plo[c] <= r_x[c][sap_pkg::FB_LO_W-1:0] * sap_pkg::FB_RECIP;
            end
            if (r_stage[1]) begin
                r_q[c] <= sap_pkg::DIV_W'(w_sum[c][sap_pkg::DIV_W+35:42]);
            end
            if (r_stage[2]) begin
                r_fix[c] <= (w_back[c] >= sap_pkg::DIV_W'(sap_pkg::FB_DIV));
            end
            if (r_stage[3]) begin
                r_quot[c] <= r_q[c] + sap_pkg::DIV_W'(r_fix[c]);
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// File: rtl/sap_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sap_cell
// One first-order allpass section for both channels.
// ----------------------------------------------------------------------------
module sap_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic [16:0]        i_gain,
    input  sap_pkg::t_tok      i_tok,
    output sap_pkg::t_tok      o_tok
);

    logic signed [31:0] r_store [2];
    logic signed [31:0] w_a;
    logic signed [31:0] w_t;
    logic               r_v;
    logic               r_ch;
    logic               r_en;
    logic signed [31:0] r_a;
    logic signed [31:0] r_t;
    sap_pkg::t_tok      r_out;
    sap_pkg::t_tok      n_out;

    always_comb begin
        w_t = r_store[i_tok.ch];
        w_a = sap_pkg::sat32(64'(sap_pkg::mul_gain(w_t, i_gain)) + 64'(i_tok.data));
    end

    // A disabled section hands its input on untouched and keeps its state.
    always_comb begin
        n_out.valid = r_v;
        n_out.ch    = r_ch;
        if (r_en) begin
            n_out.data = sap_pkg::sat32(64'(r_t) - 64'(sap_pkg::mul_gain(r_a, i_gain)));
        end else begin
            n_out.data = r_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_store[0]  <= '0;
            r_store[1]  <= '0;
            r_v         <= 1'b0;
            r_out.valid <= 1'b0;
        end else begin
            r_v         <= i_tok.valid;
            r_out.valid <= n_out.valid;
            if (i_tok.valid && i_en) begin
                r_store[i_tok.ch] <= w_a;
            end
        end
        r_ch       <= i_tok.ch;
        r_en       <= i_en;
        r_a        <= i_en ? w_a : i_tok.data;
        r_t        <= w_t;
        r_out.ch   <= n_out.ch;
        r_out.data <= n_out.data;
    end

    assign o_tok = r_out;

endmodule

// File: rtl/stereo_allpass_phaser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stereo_allpass_phaser
// Stereo phaser: feedback, LFO-modulated allpass chain and dry/wet mix.
// ----------------------------------------------------------------------------
// One stereo frame is processed at a time: a new frame is taken only after
// the last one has been mixed. Each frame passes the reciprocal divider that
// scales the feedback by the percentage, the chain of MAX_STAGES allpass
// cells (always traversed in full, the right channel entering the cycle
// after the left) and the dry/wet mixing. The LFO gain is refreshed during
// the divider phase of every LFO_INTERVAL-th frame. A finished frame waits
// in the output register while the next item is accepted; if the previous
// result is still held there when mixing ends, the block waits until it has
// been taken.
module stereo_allpass_phaser (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  sap_pkg::t_frame_in    i_data,
    output logic                  o_valid,
    input  logic                  i_stall,
    output sap_pkg::t_frame_out   o_data,
    input  logic                  i_cfg_we,
    input  logic [2:0]            i_cfg_idx,
    input  logic [31:0]           i_cfg_wdata
);

    // Configuration registers.
    logic [31:0]        r_lfo_step;
    logic [15:0]        r_start_phase;
    logic signed [7:0]  r_fb_pct;
    logic [7:0]         r_depth;
    logic [4:0]         r_stage_count;
    logic [7:0]         r_dry_wet;

    sap_pkg::t_state    r_state;
    sap_pkg::t_state    n_state;
    logic [sap_pkg::CNT_W-1:0] r_cnt;

    logic [sap_pkg::SKIP_W-1:0] r_skip;
    logic [31:0]        r_phase;
    logic               r_refresh;
    logic [16:0]        r_v;
    logic [23:0]        r_prod;
    logic [16:0]        r_gain;

    logic signed [15:0] r_in [2];
    logic signed [31:0] r_m  [2];
    logic signed [31:0] r_fb [2];

    logic signed [40:0] r_p1 [2];
    logic signed [36:0] r_p2 [2];
    logic [23:0]        r_yb [2];
    logic               r_hi [2];
    logic               r_lo [2];

    logic               r_ovalid;
    sap_pkg::t_frame_out r_out;

    // Control from the sequencer.
    logic               w_accept;
    logic               w_out_free;
    logic               w_out_load;
    sap_pkg::t_tok      w_inject;

    logic [1:0][sap_pkg::DIV_W-1:0] w_num;
    logic [1:0][sap_pkg::DIV_W-1:0] w_quot;
    logic               w_div_done;
    logic signed [41:0] w_x [2];
    logic signed [31:0] w_mq [2];

    logic [31:0]        w_angle;
    logic [sap_pkg::SKIP_W:0] w_skip_inc;

    logic signed [41:0] w_s  [2];
    logic signed [41:0] w_y  [2];
    logic [16:0]        w_q  [2];
    logic signed [15:0] w_o  [2];

    sap_pkg::t_tok      w_tok [sap_pkg::MAX_STAGES+1];

    assign w_out_free = !r_ovalid || !i_stall;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            sap_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_state = sap_pkg::S_DIV;
                end
            end
            sap_pkg::S_DIV: begin
                if (w_div_done) begin
                    n_state = sap_pkg::S_CHAIN;
                end
            end
            sap_pkg::S_CHAIN: begin
                if (w_tok[sap_pkg::MAX_STAGES].valid && w_tok[sap_pkg::MAX_STAGES].ch) begin
                    n_state = sap_pkg::S_MIX;
                end
            end
            sap_pkg::S_MIX: begin
                if (r_cnt >= sap_pkg::CNT_W'(2) && w_out_free) begin
                    n_state = sap_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = sap_pkg::S_IDLE;
            end
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        w_accept       = 1'b0;
        w_out_load     = 1'b0;
        w_inject.valid = 1'b0;
        w_inject.ch    = r_cnt[0];
        w_inject.data  = r_m[r_cnt[0]];
        case (r_state)
            sap_pkg::S_IDLE: begin
                w_accept = i_valid;
            end
            sap_pkg::S_CHAIN: begin
                w_inject.valid = (r_cnt < sap_pkg::CNT_W'(2));
            end
            sap_pkg::S_MIX: begin
                w_out_load = (r_cnt >= sap_pkg::CNT_W'(2)) && w_out_free;
            end
            default: begin
                w_accept = 1'b0;
            end
        endcase
    end

    assign o_stall = (r_state != sap_pkg::S_IDLE);

    // Feedback scaled by percent, biased so that the divider sees a positive value.
    always_comb begin
        for (int c = 0; c < 2; c++) begin
            w_x[c]   = r_fb[c] * r_fb_pct + 42'sd50 + sap_pkg::FB_BIAS;
            w_num[c] = w_x[c][sap_pkg::DIV_W-1:0];
            w_mq[c]  = sap_pkg::sat32(64'($signed({1'b0, w_quot[c]})) - sap_pkg::FB_BIAS_Q
                                      + 64'($signed({r_in[c], 12'd0})));
        end
    end

    sap_div100 u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_accept),
        .i_num   (w_num),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    assign w_tok[0] = w_inject;

    for (genvar j = 0; j < sap_pkg::MAX_STAGES; j++) begin : g_cell
        sap_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (j < int'(r_stage_count)),
            .i_gain  (r_gain),
            .i_tok   (w_tok[j]),
            .o_tok   (w_tok[j+1])
        );
    end

    assign w_angle    = r_phase + {r_start_phase, 16'd0};
    assign w_skip_inc = {1'b0, r_skip} + 1'b1;

    // Dry/wet mix: floor((sum + half) / 4096) then floor by 255 with saturation.
    always_comb begin
        for (int c = 0; c < 2; c++) begin
            w_s[c] = 42'(r_p1[c]) + 42'(r_p2[c]) + 42'sd522240;
            w_y[c] = w_s[c] >>> 12;
            w_q[c] = sap_pkg::div255(r_yb[c]);
            if (r_hi[c]) begin
                w_o[c] = 16'sh7fff;
            end else if (r_lo[c]) begin
                w_o[c] = 16'sh8000;
            end else begin
                w_o[c] = 16'(w_q[c] - 17'd32768);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lfo_step    <= 32'd35791;
            r_start_phase <= '0;
            r_fb_pct      <= '0;
            r_depth       <= 8'd100;
            r_stage_count <= 5'd2;
            r_dry_wet     <= 8'd128;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                sap_pkg::REG_LFO_STEP:    r_lfo_step    <= i_cfg_wdata;
                sap_pkg::REG_START_PHASE: r_start_phase <= i_cfg_wdata[15:0];
                sap_pkg::REG_FB_PERCENT:  r_fb_pct      <= i_cfg_wdata[7:0];
                sap_pkg::REG_DEPTH:       r_depth       <= i_cfg_wdata[7:0];
                sap_pkg::REG_STAGE_COUNT: r_stage_count <= i_cfg_wdata[4:0];
                sap_pkg::REG_DRY_WET:     r_dry_wet     <= i_cfg_wdata[7:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= sap_pkg::S_IDLE;
            r_cnt     <= '0;
            r_skip    <= '0;
            r_phase   <= '0;
            r_refresh <= 1'b0;
            r_gain    <= '0;
            r_fb[0]   <= '0;
            r_fb[1]   <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (n_state != r_state) begin
                r_cnt <= '0;
            end else if (r_state != sap_pkg::S_IDLE && r_cnt != {sap_pkg::CNT_W{1'b1}}) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (w_accept) begin
                r_phase   <= r_phase + r_lfo_step;
                r_refresh <= (r_skip == '0);
                if (w_skip_inc >= (sap_pkg::SKIP_W+1)'(sap_pkg::LFO_INTERVAL)) begin
                    r_skip <= '0;
                end else begin
                    r_skip <= w_skip_inc[sap_pkg::SKIP_W-1:0];
                end
            end
            if (r_state == sap_pkg::S_DIV && r_refresh && r_cnt == sap_pkg::CNT_W'(2)) begin
                r_gain <= 17'(18'd65536 - {1'b0, sap_pkg::div255(r_prod)});
            end
            if (w_tok[sap_pkg::MAX_STAGES].valid) begin
                r_fb[w_tok[sap_pkg::MAX_STAGES].ch] <= w_tok[sap_pkg::MAX_STAGES].data;
            end
            if (w_out_load) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && !i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in[0] <= i_data.left_sample;
            r_in[1] <= i_data.right_sample;
        end
        // Gain refresh steps: table read, depth product.
        if (r_state == sap_pkg::S_DIV && r_cnt == sap_pkg::CNT_W'(0)) begin
            r_v <= sap_pkg::GAIN_TAB[w_angle[31 -: sap_pkg::GT_BITS]];
        end
        if (r_state == sap_pkg::S_DIV && r_cnt == sap_pkg::CNT_W'(1)) begin
            r_prod <= 24'(r_v * r_depth + 25'd127);
        end
        if (r_state == sap_pkg::S_DIV && w_div_done) begin
            r_m[0] <= w_mq[0];
            r_m[1] <= w_mq[1];
        end
        if (w_tok[sap_pkg::MAX_STAGES].valid) begin
            r_m[w_tok[sap_pkg::MAX_STAGES].ch] <= w_tok[sap_pkg::MAX_STAGES].data;
        end
        for (int c = 0; c < 2; c++) begin
            if (r_state == sap_pkg::S_MIX && r_cnt == sap_pkg::CNT_W'(0)) begin
                r_p1[c] <= r_m[c] * $signed({1'b0, r_dry_wet});
                r_p2[c] <= $signed({r_in[c], 12'd0}) * $signed({1'b0, 8'(8'd255 - r_dry_wet)});
            end
            if (r_state == sap_pkg::S_MIX && r_cnt == sap_pkg::CNT_W'(1)) begin
                r_hi[c] <= (w_y[c] >= 42'sd8355840);
                r_lo[c] <= (w_y[c] < -42'sd8355840);
                r_yb[c] <= 24'(w_y[c] + 42'sd8355840);
            end
        end
        if (w_out_load) begin
            r_out.left_out  <= w_o[0];
            r_out.right_out <= w_o[1];
        end
    end

    assign o_valid = r_ovalid;
    assign o_data  = r_out;

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the stereo allpass phaser.
// A table of directed frames and register writes comes first. Phases of
// random frames follow, each under its own register setting. Every accepted
// frame is run through a local fixed-point model of the phaser. Each frame
// that leaves the block is compared with the oldest expected frame. Both
// handshakes idle and stall at random.
// ----------------------------------------------------------------------------
module tb;

    typedef enum int {ROW_FRAME, ROW_CFG} t_row_kind;

    typedef struct {
        t_row_kind          kind;
        logic signed [15:0] l;
        logic signed [15:0] r;
        bit                 typed;
        logic signed [15:0] el;
        logic signed [15:0] er;
        logic [2:0]         idx;
        logic [31:0]        val;
    } t_row;

    localparam int STAGES_MAX   = 24;
    localparam int WATCH_LIMIT  = 4000;
    localparam int SETTLE_CYCLES = 200;

    // Indexes past the end of the register list; writes to them are ignored.
    localparam logic [2:0] IDX_SPARE_LO = 3'd6;
    localparam logic [2:0] IDX_SPARE_HI = 3'd7;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_valid = 1'b0;
    logic                   o_stall;
    sap_pkg::t_frame_in     i_data = '0;
    logic                   o_valid;
    logic                   i_stall = 1'b0;
    sap_pkg::t_frame_out    o_data;
    logic                   i_cfg_we = 1'b0;
    logic [2:0]             i_cfg_idx = '0;
    logic [31:0]            i_cfg_wdata = '0;

    stereo_allpass_phaser u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data      (i_data),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_data      (o_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Phaser model state and registers.
    bit [31:0]   m_lfo_step;
    bit [15:0]   m_start_phase;
    int          m_fb_pct;
    int          m_depth;
    int          m_stages;
    int          m_dry_wet;
    int          m_skip;
    bit [31:0]   m_phase;
    int          m_gain;
    int          m_cells [2*STAGES_MAX];
    int          m_fb [2];
    int          shape_tab [256];

    sap_pkg::t_frame_out frames_due [$];
    int  fails = 0;
    int  frames_in = 0;
    int  frames_out = 0;
    int  cfg_writes = 0;
    int  quiet_cycles = 0;
    bit  idling_on = 1'b1;

    function automatic longint rdiv(longint n, longint d);
        longint r;
        r = n + d / 2;
        if (r >= 0) begin
            return r / d;
        end
        return -((-r + d - 1) / d);
    endfunction

    function automatic int clip32(longint v);
        if (v > 64'sd2147483647) begin
            return 32'sh7fffffff;
        end
        if (v < -64'sd2147483648) begin
            return 32'sh80000000;
        end
        return int'(v);
    endfunction

    function automatic longint unsigned exp_pow4(longint unsigned u);
        longint unsigned acc;
        longint unsigned term;
        longint unsigned sq;
        longint unsigned qt;
        acc  = 64'd1 << 30;
        term = 64'd1 << 30;
        for (int k = 1; k <= 16; k++) begin
            term = ((term * u) >> 30) / k;
            acc  = acc + term;
        end
        sq = (acc * acc) >> 30;
        qt = sq >> 2;
        return (qt * qt) >> 26;
    endfunction

    // Exponential-shaped cosine at one table position, unsigned Q1.16.
    function automatic int shape_at(int idx);
        longint unsigned x;
        longint unsigned t;
        longint unsigned t2;
        longint unsigned term;
        longint unsigned c;
        longint unsigned den;
        longint unsigned v;
        longint          acc;
        x    = (longint'(idx) * 65536) / 256;
        term = 64'd1 << 30;
        acc  = 64'sd1 << 30;
        if (x > 32768) begin
            x = 65536 - x;
        end
        t  = (x * 64'd3373259426) >> 16;
        t2 = (t * t) >> 30;
        for (int k = 1; k <= 7; k++) begin
            term = ((term * t2) >> 30) / ((2 * k - 1) * (2 * k));
            if (k % 2 == 1) begin
                acc = acc - longint'(term);
            end else begin
                acc = acc + longint'(term);
            end
        end
        if (acc < 0) begin
            acc = 0;
        end
        if (acc > (64'sd1 << 30)) begin
            acc = 64'sd1 << 30;
        end
        c   = acc;
        den = exp_pow4(64'd1 << 30) - (64'd1 << 30);
        v   = (((exp_pow4((c * c) >> 30) - (64'd1 << 30)) << 16) + den / 2) / den;
        if (v > 65536) begin
            v = 65536;
        end
        return int'(v);
    endfunction

    function automatic int gain_mul(int a, int g);
        return clip32(rdiv(longint'(a) * longint'(g), 65536));
    endfunction

    function automatic logic signed [15:0] phase_channel(int ch, logic signed [15:0] s);
        longint in27;
        longint mix;
        int     m;
        int     t;
        int     n;
        in27 = longint'(s) * 4096;
        m    = clip32(in27 + rdiv(longint'(m_fb[ch]) * m_fb_pct, 100));
        n    = (m_stages > STAGES_MAX) ? STAGES_MAX : m_stages;
        for (int j = 0; j < n; j++) begin
            t = m_cells[ch*STAGES_MAX + j];
            m_cells[ch*STAGES_MAX + j] = clip32(longint'(gain_mul(t, m_gain)) + m);
            m = clip32(longint'(t) - gain_mul(m_cells[ch*STAGES_MAX + j], m_gain));
        end
        m_fb[ch] = m;
        mix = longint'(m) * m_dry_wet + in27 * (255 - m_dry_wet);
        mix = rdiv(mix, 255 * 4096);
        if (mix > 32767) begin
            mix = 32767;
        end
        if (mix < -32768) begin
            mix = -32768;
        end
        return mix[15:0];
    endfunction

    function automatic sap_pkg::t_frame_out phase_frame(sap_pkg::t_frame_in f);
        sap_pkg::t_frame_out o;
        bit [31:0] angle;
        m_phase = m_phase + m_lfo_step;
        if (m_skip == 0) begin
            angle  = m_phase + {m_start_phase, 16'd0};
            m_gain = 65536 - (shape_tab[angle[31:24]] * m_depth + 127) / 255;
        end
        m_skip = (m_skip + 1 >= 20) ? 0 : m_skip + 1;
        o.left_out  = phase_channel(0, f.left_sample);
        o.right_out = phase_channel(1, f.right_sample);
        return o;
    endfunction

    function automatic void model_reset();
        m_lfo_step    = 32'd35791;
        m_start_phase = '0;
        m_fb_pct      = 0;
        m_depth       = 100;
        m_stages      = 2;
        m_dry_wet     = 128;
        m_skip        = 0;
        m_phase       = '0;
        m_gain        = 0;
        foreach (m_cells[i]) m_cells[i] = 0;
        m_fb[0] = 0;
        m_fb[1] = 0;
    endfunction

    // Register write; the caller lowers the write enable after a batch.
    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        cfg_writes++;
        case (idx)
            sap_pkg::REG_LFO_STEP:    m_lfo_step    = val;
            sap_pkg::REG_START_PHASE: m_start_phase = val[15:0];
            sap_pkg::REG_FB_PERCENT:  m_fb_pct      = int'($signed(val[7:0]));
            sap_pkg::REG_DEPTH:       m_depth       = int'(val[7:0]);
            sap_pkg::REG_STAGE_COUNT: m_stages      = int'(val[4:0]);
            sap_pkg::REG_DRY_WET:     m_dry_wet     = int'(val[7:0]);
            default: ;
        endcase
    endtask

    // Holds the sender back until every predicted frame has come out.
    task automatic drain();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (frames_due.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic send_frame(sap_pkg::t_frame_in f, bit typed, sap_pkg::t_frame_out fixed);
        sap_pkg::t_frame_out pred;
        if (idling_on && $urandom_range(0, 99) < 18) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= f;
        do @(posedge i_clk); while (o_stall);
        pred = phase_frame(f);
        frames_due.push_back(typed ? fixed : pred);
        frames_in++;
        @(negedge i_clk);
    endtask

    function automatic t_row fr(int l, int r);
        t_row x;
        x = '{ROW_FRAME, l[15:0], r[15:0], 1'b0, '0, '0, '0, '0};
        return x;
    endfunction

    function automatic t_row frx(int l, int r, int el, int er);
        t_row x;
        x = '{ROW_FRAME, l[15:0], r[15:0], 1'b1, el[15:0], er[15:0], '0, '0};
        return x;
    endfunction

    function automatic t_row cf(logic [2:0] idx, logic [31:0] val);
        t_row x;
        x = '{ROW_CFG, '0, '0, 1'b0, '0, '0, idx, val};
        return x;
    endfunction

    t_row stim_table [] = '{
        frx(0, 0, 0, 0),
        fr(32767, -32768), fr(-32768, 32767), fr(1, -1), fr(-1, 1),
        // A fully dry mix passes the input through untouched.
        cf(sap_pkg::REG_DRY_WET, 32'd0),
        frx(32767, -32768, 32767, -32768), frx(-32768, 32767, -32768, 32767),
        frx(12345, -4321, 12345, -4321),
        cf(sap_pkg::REG_DRY_WET, 32'd255), cf(sap_pkg::REG_STAGE_COUNT, 32'd0),
        cf(sap_pkg::REG_FB_PERCENT, 32'd127), cf(sap_pkg::REG_DEPTH, 32'd255),
        fr(32767, 32767), fr(32767, -32768), fr(-32768, -32768),
        cf(sap_pkg::REG_STAGE_COUNT, 32'd31), cf(sap_pkg::REG_FB_PERCENT, 32'h80),
        cf(sap_pkg::REG_LFO_STEP, 32'hffffffff), cf(sap_pkg::REG_START_PHASE, 32'hffff),
        cf(IDX_SPARE_LO, 32'hffffffff), cf(IDX_SPARE_HI, 32'h5a5a5a5a),
        fr(-32768, 32767), fr(20000, -20000), fr(0, 0),
        cf(sap_pkg::REG_LFO_STEP, 32'd0), cf(sap_pkg::REG_DEPTH, 32'd0),
        cf(sap_pkg::REG_STAGE_COUNT, 32'd24), cf(sap_pkg::REG_FB_PERCENT, 32'd100),
        fr(32767, -32768), fr(-5, 7), fr(-32768, 32767)
    };

    task automatic random_settings();
        bit [31:0] step;
        case ($urandom_range(0, 3))
            0: step = 32'd0;
            1: step = 32'hffffffff;
            2: step = $urandom_range(0, 400000);
            default: step = $urandom;
        endcase
        write_reg(sap_pkg::REG_LFO_STEP, step);
        write_reg(sap_pkg::REG_START_PHASE, $urandom);
        write_reg(sap_pkg::REG_FB_PERCENT, $urandom);
        write_reg(sap_pkg::REG_DEPTH, $urandom);
        write_reg(sap_pkg::REG_STAGE_COUNT, $urandom);
        write_reg(sap_pkg::REG_DRY_WET, $urandom);
        if ($urandom_range(0, 3) == 0) begin
            write_reg(3'($urandom_range(IDX_SPARE_LO, IDX_SPARE_HI)), $urandom);
        end
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic signed [15:0] rand_sample();
        case ($urandom_range(0, 7))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return 16'($urandom_range(0, 64)) - 16'sd32;
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        sap_pkg::t_frame_in  f;
        sap_pkg::t_frame_out fixed;
        bit                  cfg_open;
        foreach (shape_tab[i]) shape_tab[i] = shape_at(i);
        model_reset();
        cfg_open = 1'b0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (stim_table[i]) begin
            if (stim_table[i].kind == ROW_CFG) begin
                if (!cfg_open) begin
                    drain();
                    cfg_open = 1'b1;
                end
                write_reg(stim_table[i].idx, stim_table[i].val);
            end else begin
                if (cfg_open) begin
                    @(negedge i_clk);
                    i_cfg_we <= 1'b0;
                    cfg_open = 1'b0;
                end
                f.left_sample    = stim_table[i].l;
                f.right_sample   = stim_table[i].r;
                fixed.left_out   = stim_table[i].el;
                fixed.right_out  = stim_table[i].er;
                send_frame(f, stim_table[i].typed, fixed);
            end
        end

        for (int ph = 0; ph < 8; ph++) begin
            drain();
            random_settings();
            // One phase runs with both sides flat out.
            idling_on = (ph != 3);
            for (int n = 0; n < 100; n++) begin
                f.left_sample  = rand_sample();
                f.right_sample = rand_sample();
                send_frame(f, 1'b0, fixed);
            end
        end
        idling_on = 1'b1;
        i_valid <= 1'b0;

        while (frames_due.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        $display("Ran %0d frames through the phaser with %0d register writes;", frames_in,
                 cfg_writes);
        $display("%0d output frames were checked against the fixed-point model.", frames_out);
        if (fails == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    always @(negedge i_clk) begin
        i_stall <= idling_on && ($urandom_range(0, 99) < 18);
    end

    always @(posedge i_clk) begin
        sap_pkg::t_frame_out want;
        if (o_valid && !i_stall) begin
            frames_out++;
            if (frames_due.size() == 0) begin
                fails++;
                $display("%0t: unexpected output frame %h", $time, o_data);
            end else begin
                want = frames_due.pop_front();
                if (o_data.left_out !== want.left_out) begin
                    fails++;
                    $display("%0t: left_out expected %0d, got %0d", $time,
                             want.left_out, o_data.left_out);
                end
                if (o_data.right_out !== want.right_out) begin
                    fails++;
                    $display("%0t: right_out expected %0d, got %0d", $time,
                             want.right_out, o_data.right_out);
                end
            end
        end
    end

    // The run is abandoned when no item moves on either side for too long.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || !i_rst_n) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCH_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, WATCH_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule

// File: stereo_allpass_phaser.f
rtl/sap_pkg.sv
rtl/sap_div100.sv
rtl/sap_cell.sv
rtl/stereo_allpass_phaser.sv
tb/sv/tb.sv
